/* src/fir_lp_pkg.sv */
// Package for the 23-tap low-pass FIR: tap count and coefficient table.
// Depends on nothing; used by the cells and the top level.
`default_nettype none

package fir_lp_pkg;

  localparam int TAPS            = 23;
  localparam int HALF_TAPS       = 12;
  localparam int TABLE_FRAC_BITS = 30;
  localparam int GUARD_BITS      = 5;   // sum of |coef| stays below 2^5

  // Distinct coefficients for taps 0..11 in Q2.30; the rest mirror them
  localparam longint COEF_Q30 [HALF_TAPS] = '{
    -64'sd9334064,   -64'sd10089800,  -64'sd11061750,  -64'sd6840400,
    64'sd4573377,    64'sd24560611,   64'sd52251262,   64'sd85269017,
    64'sd119047140,  64'sd148578386,  64'sd168614638,  64'sd175810230
  };

  // Coefficient of tap n with frac fraction bits, rounded half away from zero
  function automatic longint coef_at(input int n, input int frac);
    int     k;
    int     sh;
    longint v;
    longint mag;
    logic   neg;
    k = (n < HALF_TAPS) ? n : (TAPS - 1 - n);
    if (k < 0) k = 0;
    if (k >= HALF_TAPS) k = HALF_TAPS - 1;
    sh = TABLE_FRAC_BITS - frac;
    v = COEF_Q30[k];
    if (sh <= 0) return v;
    neg = (v < 0);
    mag = neg ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
    return neg ? -mag : mag;
  endfunction

endpackage

`default_nettype wire

/* src/fir_lp_if.sv */
// Valid/ready channel interfaces for the FIR input and output words.
// No dependencies.
`default_nettype none

interface fir_lp_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fir_lp_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] filtered;
  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

/* src/fir_lp_cell.sv */
// One transposed-form FIR cell: multiply the new sample by its tap and add
// the neighbor's partial sum. Uses fir_lp_pkg.
`default_nettype none

module fir_lp_cell #(
  parameter int SW = 16,
  parameter int CW = 16,
  parameter int AW = 37
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic signed [SW-1:0] sample_i,
  input  logic signed [CW-1:0] coef_i,
  input  logic signed [AW-1:0] sum_i,
  output logic signed [AW-1:0] sum_o
);
  import fir_lp_pkg::*;

  logic signed [SW+CW-1:0] prod;
  logic signed [AW-1:0]    sum_d;
  logic signed [AW-1:0]    sum_q;

  assign prod  = sample_i * coef_i;
  assign sum_d = AW'(prod) + sum_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

/* src/fir_lowpass_23tap_top.sv */
// 23-tap low-pass FIR, transposed form: a chain of multiply-add cells.
// Each word's sum lands in the cell 0 sum register, then passes to the
// round/saturate register. Throughput: one word per cycle; the input
// stalls only while both the sum and output registers hold untaken words.
// Reset (async, active low) zeroes all partial sums, i.e. an all-zero
// sample history, and empties both stages. Uses fir_lp_pkg, fir_lp_if.
`default_nettype none

module fir_lowpass_23tap_top #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic clk_i,
  input  logic rst_ni,
  fir_lp_in_if.sink    in_i,
  fir_lp_out_if.source out_o
);
  import fir_lp_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COEF_FRAC_BITS + 1;       // all taps |c| < 0.5
  localparam int AW = SW + CW + GUARD_BITS;     // exact accumulator

  // Partial sums; sums[0] is the finished filter output for the last word
  logic signed [AW-1:0] sums [TAPS];
  logic                 accept;
  logic                 acc_v_q;
  logic                 out_v_q;
  logic                 out_load;
  logic signed [SW-1:0] filt_q;
  logic signed [SW-1:0] filt_d;

  assign out_load    = acc_v_q && (!out_v_q || out_o.ready);
  // Cell 0 holds the finished sum, so it may only be replaced once it moves on
  assign in_i.ready  = !acc_v_q || out_load;
  assign accept      = in_i.valid && in_i.ready;

  // Chain of cells: cell k adds c[k]*x to the partial sum of cell k+1
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    localparam longint CoefL = coef_at(k, COEF_FRAC_BITS);
    localparam logic signed [CW-1:0] Coef = CW'(CoefL);
    logic signed [AW-1:0] sum_in;

    if (k == TAPS - 1) begin : g_last
      assign sum_in = '0;
    end else begin : g_mid
      assign sum_in = sums[k+1];
    end

    fir_lp_cell #(
      .SW (SW),
      .CW (CW),
      .AW (AW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .sample_i (in_i.sample),
      .coef_i   (Coef),
      .sum_i    (sum_in),
      .sum_o    (sums[k])
    );
  end

  // Round half up, drop fraction bits, then clamp to the sample range
  logic signed [AW-1:0] rnd_sum;
  logic signed [AW-1:0] shifted;
  logic                 in_range;

  assign rnd_sum  = sums[0] + (AW'(1) <<< (COEF_FRAC_BITS - 1));
  assign shifted  = rnd_sum >>> COEF_FRAC_BITS;
  // in range when every bit from the sample sign up matches the top bit
  assign in_range = (shifted[AW-1:SW-1] == '0) || (shifted[AW-1:SW-1] == '1);

  always_comb begin
    if (in_range) begin
      filt_d = shifted[SW-1:0];
    end else if (shifted[AW-1]) begin
      filt_d = {1'b1, {(SW-1){1'b0}}};
    end else begin
      filt_d = {1'b0, {(SW-1){1'b1}}};
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        acc_v_q <= 1'b1;
      end else if (out_load) begin
        acc_v_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filt_q <= filt_d;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.filtered = filt_q;

endmodule

`default_nettype wire

/* test/fir_lp_checker.sv */
// Checker for the 23-tap low-pass FIR: watches both channels, predicts each
// filtered word and compares it in order. Uses fir_lp_pkg for the tap count.
`default_nettype none

module fir_lp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] in_sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] out_filtered_i,
  output int                 pending_o,
  output int                 fails_o
);

  localparam int     NTAP     = fir_lp_pkg::TAPS;
  localparam int     HALF     = fir_lp_pkg::HALF_TAPS;
  localparam int     FRAC     = 15;
  localparam longint SAT_HI   = 32767;
  localparam longint SAT_LO   = -32768;

  // Q1.15 taps 0..11, half away from zero from the Q2.30 design values;
  // taps 12..22 mirror these
  localparam int TAP_Q15 [HALF] = '{
    -285, -308, -338, -209, 140, 750, 1595, 2602, 3633, 4534, 5146, 5365
  };

  logic signed [15:0] history [NTAP];   // newest sample at index 0
  logic signed [15:0] filt_expected [$];
  logic signed [15:0] oldest_filt;
  int                 fails = 0;

  function automatic logic signed [15:0] fir_step(input logic signed [15:0] w);
    longint acc;
    longint q;
    int     n;
    int     k;
    for (n = NTAP - 1; n > 0; n--) history[n] = history[n-1];
    history[0] = w;
    acc = 0;
    for (n = 0; n < NTAP; n++) begin
      k = (n < HALF) ? n : (NTAP - 1 - n);
      acc += longint'(TAP_Q15[k]) * longint'(history[n]);
    end
    // round to nearest, ties up, then saturate
    q = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[15:0];
  endfunction

  task automatic flag_mismatch(input string what);
    fails++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NTAP; i++) history[i] = '0;
      filt_expected.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (filt_expected.size() == 0) begin
          flag_mismatch($sformatf("filtered word %0d with nothing expected",
                                  out_filtered_i));
        end else begin
          oldest_filt = filt_expected.pop_front();
          if (out_filtered_i !== oldest_filt)
            flag_mismatch($sformatf("filtered got %0d want %0d",
                                    out_filtered_i, oldest_filt));
        end
      end
      if (in_valid_i && in_ready_i) filt_expected.push_back(fir_step(in_sample_i));
      pending_o = filt_expected.size();
    end
    fails_o = fails;
  end

endmodule

`default_nettype wire

/* test/tb.sv */
// Top of the FIR testbench: clock, reset, sample stimulus and output stalls.
// Uses fir_lp_pkg, fir_lp_if, fir_lowpass_23tap_top and fir_lp_checker.
`default_nettype none

module tb;

  localparam int SEND_TOTAL      = 875;   // 25 directed + about 850 random
  localparam int TAIL_START      = 780;   // no idling on either side past this
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_CYCLES    = 10;

  // kinds of random segments fed to the filter
  typedef enum int {SEG_NOISE, SEG_RAIL, SEG_TOGGLE, SEG_DRIFT, SEG_QUIET} seg_kind_e;

  logic clk;
  logic rst_n;
  int   sent_words = 0;
  bit   tail_phase = 1'b0;
  bit   held_off   = 1'b0;
  int   pending;
  int   fails;

  fir_lp_in_if  #(.W(16)) in_w ();
  fir_lp_out_if #(.W(16)) out_w ();

  fir_lowpass_23tap_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  fir_lp_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_w.valid),
    .in_ready_i     (in_w.ready),
    .in_sample_i    (in_w.sample),
    .out_valid_i    (out_w.valid),
    .out_ready_i    (out_w.ready),
    .out_filtered_i (out_w.filtered),
    .pending_o      (pending),
    .fails_o        (fails)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // single reset pulse at the start, async assert, released on an edge
  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("fir_lowpass_23tap_top verification failed");
    $finish;
  end

  // Offer one word and hold it until the block takes it. valid stays high
  // into the next word unless an idle burst follows, so it is never
  // dropped and raised in the same step.
  task automatic send_word(input logic signed [15:0] w);
    in_w.valid  <= 1'b1;
    in_w.sample <= w;
    @(posedge clk);
    while (!in_w.ready) @(posedge clk);
    sent_words++;
    if (sent_words >= TAIL_START) tail_phase = 1'b1;
    if (!tail_phase && $urandom_range(0, 4) == 0) begin
      in_w.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Saturating add for drift segments so the level stays a legal sample.
  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Sample stimulus
  initial begin
    logic signed [15:0] opening [7];
    seg_kind_e          kind;
    int                 seg_len;
    int                 level;
    logic signed [15:0] w;

    opening = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1,
                16'sh5555, 16'shaaaa};
    in_w.valid  <= 1'b0;
    in_w.sample <= '0;
    wait (rst_n);
    @(posedge clk);

    // Directed: field extremes, zero, single-LSB values and alternating-bit
    // patterns, then a run at the positive rail long enough to push the sum past full scale.
    foreach (opening[i]) send_word(opening[i]);
    repeat (18) send_word(16'sh7fff);

    // Random segments: mostly shaped signals, some plain noise. Rail runs
    // are long enough to fill most of the window and force saturation.
    while (sent_words < SEND_TOTAL) begin
      kind  = seg_kind_e'($urandom_range(0, 4));
      level = int'($urandom_range(0, 65535)) - 32768;
      seg_len = (kind == SEG_RAIL) ? $urandom_range(20, 40) : $urandom_range(1, 30);
      if (kind == SEG_RAIL) level = $urandom_range(0, 1) ? 32767 : -32768;
      for (int i = 0; i < seg_len; i++) begin
        case (kind)
          SEG_NOISE:  w = 16'($urandom);
          SEG_RAIL:   w = level[15:0];
          SEG_TOGGLE: w = (i % 2) ? 16'sh7fff : 16'sh8000;
          SEG_DRIFT: begin
            level = int'(clamp16(level + int'($urandom_range(0, 63)) - 32));
            w = level[15:0];
          end
          default:    w = clamp16(int'($urandom_range(0, 15)) - 8);
        endcase
        send_word(w);
      end
    end
    in_w.valid <= 1'b0;
    @(posedge clk);

    // drain: everything predicted must come out, then a few quiet cycles
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("fir_lowpass_23tap_top verification clean");
    end else begin
      $display("fir_lowpass_23tap_top verification failed");
    end
    $finish;
  end

  // Output side: random stall bursts, one long hold-off mid-run so both
  // stages fill and the input backs up, and a steady ready in the tail.
  initial begin
    out_w.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && sent_words >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        out_w.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
        out_w.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_w.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

endmodule

`default_nettype wire
